/* design/rmic_pkg.sv */
// Shared types, register indexes and saturation helpers for the row mean block.
package rmic_pkg;

  localparam int VAL_W  = 32;
  localparam int SUM_W  = 56;
  localparam int RSUM_W = 40;
  localparam int NR_W   = 21;
  localparam int NC_W   = 7;
  localparam int COL_W  = 6;
  localparam int IDX_W  = 3;
  localparam int DIV_W  = 56;
  localparam int EMIT_CAP = 64;
  localparam logic signed [VAL_W-1:0] MISSING_RESET = 32'sd589824;

  typedef enum logic [IDX_W-1:0] {
    REG_IMPUTE      = 3'd0,
    REG_CENTER_ROWS = 3'd1,
    REG_CENTER_COLS = 3'd2,
    REG_NUM_COLS    = 3'd3,
    REG_NUM_ROWS    = 3'd4,
    REG_MISSING     = 3'd5
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MDIV = 6'b000010,
    S_RD   = 6'b000100,
    S_ADJ  = 6'b001000,
    S_CDIV = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W+1:0] v);
    if (v > 58'sh7FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -58'sh80000000) begin
      return 32'sh80000000;
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] sat56(input logic signed [SUM_W+1:0] v);
    if (v > 58'sh7FFFFFFFFFFFFF) begin
      return 56'sh7FFFFFFFFFFFFF;
    end else if (v < -58'sh80000000000000) begin
      return 56'sh80000000000000;
    end else begin
      return v[SUM_W-1:0];
    end
  endfunction

endpackage

/* design/rmic_if.sv */
// Valid/ready channel interfaces for elements, results and register writes.
interface rmic_elem_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface rmic_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [5:0]  column;
  logic        row_last;
  modport source (output valid, output result_value, output column, output row_last,
                  input ready);
  modport sink   (input valid, input result_value, input column, input row_last,
                  output ready);
endinterface

interface rmic_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/row_mean_impute_and_center.sv */
// Row mean imputation and row/column centering of a row-ordered matrix stream.
//
// Elements arrive on elem (op, value) one beat per cycle while the block is
// loading a row. When the beat that completes a row of num_cols elements is
// taken, the row mean is formed by a one-bit-per-cycle divider (skipped when
// no element counted). Each column then passes through a read state and an
// adjust state of the row and column-sum memories. Statistics rows (op 0 on
// the last beat) only update column sums. Preprocess rows emit one result
// beat per column on result, each held in an output register; with column
// centering each column adds a division of its sum by num_rows. No element
// is taken until the row-end work is finished and, for preprocess rows, the
// whole row has been delivered.
// A stalled receiver simply holds the current result beat; nothing is lost.
// Registers are written on cfg at any time, and cfg is always ready; they
// should change only between items. Synchronous reset returns the registers
// to their defaults, clears the row counters and marks every column sum as
// zero at once through per-column valid bits; the row buffer needs no clearing.
module row_mean_impute_and_center #(
  parameter int MAX_COLS = 64
) (
  input logic clk,
  input logic rst,
  rmic_elem_if.sink  elem,
  rmic_res_if.source result,
  rmic_cfg_if.sink   cfg
);
  import rmic_pkg::*;

  localparam int CAP = (MAX_COLS < EMIT_CAP) ? MAX_COLS : EMIT_CAP;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW  = $clog2(CAP + 1);

  // Configuration registers.
  logic                    impute_missing;
  logic                    center_rows;
  logic                    center_columns;
  logic [NC_W-1:0]         num_cols;
  logic [NR_W-1:0]         num_rows;
  logic signed [VAL_W-1:0] missing_code;

  // Storage.
  logic signed [VAL_W-1:0] row_store [CAP];
  logic signed [SUM_W-1:0] column_sums [CAP];
  logic [CAP-1:0]          cs_valid;

  state_t                   state;
  logic [CW-1:0]            element_count;
  logic signed [RSUM_W-1:0] row_sum;
  logic [CW-1:0]            present_count;
  logic                     row_op;
  logic [CW-1:0]            row_n;
  logic [AW-1:0]            col;
  logic signed [VAL_W-1:0]  mean;
  logic signed [VAL_W-1:0]  rs_rd;
  logic signed [SUM_W-1:0]  cs_rd;
  logic                     cs_vld_rd;
  logic signed [VAL_W-1:0]  adj;
  logic signed [VAL_W-1:0]  res_value;
  logic [COL_W-1:0]         res_col;
  logic                     res_last;

  // Serial divider.
  logic [DIV_W-1:0] div_quo;
  logic [NR_W-1:0]  div_rem;
  logic [NR_W-1:0]  div_d;
  logic             div_neg;
  logic [5:0]       div_cnt;

  logic [NR_W:0]           div_shift;
  logic                    div_ge;
  logic [DIV_W-1:0]        quo_next;
  logic signed [DIV_W:0]   quo_signed;
  logic                    div_last;

  logic [NC_W-1:0]          n_raw;
  logic [CW-1:0]            n_act;
  logic                     take;
  logic                     counted;
  logic signed [RSUM_W-1:0] row_sum_next;
  logic [CW-1:0]            present_next;
  logic [CW-1:0]            count_next;
  logic                     row_end;
  logic signed [SUM_W-1:0]  cs_eff;
  logic                     miss;
  logic signed [SUM_W+1:0]  a_wide;
  logic signed [VAL_W-1:0]  a_sat;
  logic signed [SUM_W-1:0]  cs_new;
  logic                     col_last;
  logic signed [SUM_W-1:0]  rs_ext;

  assign div_shift  = {div_rem, div_quo[DIV_W-1]};
  assign div_ge     = div_shift >= {1'b0, div_d};
  assign quo_next   = {div_quo[DIV_W-2:0], div_ge};
  assign quo_signed = div_neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
  assign div_last   = div_cnt == 6'(DIV_W - 1);

  always_comb begin
    n_raw = (num_cols == '0) ? NC_W'(1) : num_cols;
    if (n_raw > NC_W'(CAP)) begin
      n_act = CW'(CAP);
    end else begin
      n_act = CW'(n_raw);
    end
  end

  assign take         = elem.valid && elem.ready;
  assign counted      = !impute_missing || (elem.value != missing_code);
  assign row_sum_next = row_sum + (counted ? RSUM_W'($signed(elem.value)) : '0);
  assign present_next = present_count + (counted ? CW'(1) : CW'(0));
  assign count_next   = element_count + CW'(1);
  assign row_end      = count_next >= n_act;

  assign cs_eff   = cs_vld_rd ? cs_rd : '0;
  assign miss     = impute_missing && (rs_rd == missing_code);
  assign a_wide   = (miss ? (SUM_W+2)'(mean) : (SUM_W+2)'(rs_rd))
                    - (center_rows ? (SUM_W+2)'(mean) : '0);
  assign a_sat    = sat32(a_wide);
  assign cs_new   = sat56((SUM_W+2)'(cs_eff) + (SUM_W+2)'(a_sat));
  assign col_last = (CW'(col) + CW'(1)) == row_n;
  assign rs_ext   = SUM_W'(row_sum_next);

  assign elem.ready          = state == S_IDLE;
  assign cfg.ready           = 1'b1;
  assign result.valid        = state == S_OUT;
  assign result.result_value = res_value;
  assign result.column       = res_col;
  assign result.row_last     = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      impute_missing <= 1'b0;
      center_rows    <= 1'b0;
      center_columns <= 1'b0;
      num_cols       <= NC_W'(EMIT_CAP);
      num_rows       <= NR_W'(1);
      missing_code   <= MISSING_RESET;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_IMPUTE:      impute_missing <= cfg.data[0];
        REG_CENTER_ROWS: center_rows    <= cfg.data[0];
        REG_CENTER_COLS: center_columns <= cfg.data[0];
        REG_NUM_COLS:    num_cols       <= cfg.data[NC_W-1:0];
        REG_NUM_ROWS:    num_rows       <= cfg.data[NR_W-1:0];
        REG_MISSING:     missing_code   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Memory ports: row buffer written on load, column sums written on statistics rows, both memories read per column.
  always_ff @(posedge clk) begin
    if (take) begin
      row_store[element_count[AW-1:0]] <= elem.value;
    end
    if (state == S_ADJ && !row_op) begin
      column_sums[col] <= cs_new;
    end
    if (state == S_RD) begin
      rs_rd <= row_store[col];
      cs_rd <= column_sums[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      element_count <= '0;
      row_sum       <= '0;
      present_count <= '0;
      cs_valid      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (row_end) begin
              element_count <= '0;
              row_sum       <= '0;
              present_count <= '0;
              row_op        <= elem.op;
              row_n         <= n_act;
              col           <= '0;
              if (present_next == '0) begin
                mean  <= '0;
                state <= S_RD;
              end else begin
                div_neg <= rs_ext[SUM_W-1];
                div_quo <= rs_ext[SUM_W-1] ? DIV_W'(-rs_ext) : DIV_W'(rs_ext);
                div_d   <= NR_W'(present_next);
                div_rem <= '0;
                div_cnt <= '0;
                state   <= S_MDIV;
              end
            end else begin
              element_count <= count_next;
              row_sum       <= row_sum_next;
              present_count <= present_next;
            end
          end
        end
        S_MDIV: begin
          div_quo <= quo_next;
          div_rem <= div_ge ? NR_W'(div_shift - {1'b0, div_d}) : NR_W'(div_shift);
          div_cnt <= div_cnt + 6'd1;
          if (div_last) begin
            mean  <= quo_signed[VAL_W-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          cs_vld_rd <= cs_valid[col];
          state     <= S_ADJ;
        end
        S_ADJ: begin
          adj <= a_sat;
          if (!row_op) begin
            cs_valid[col] <= 1'b1;
            if (col_last) begin
              state <= S_IDLE;
            end else begin
              col   <= col + AW'(1);
              state <= S_RD;
            end
          end else begin
            res_col  <= COL_W'(col);
            res_last <= col_last;
            if (center_columns) begin
              div_neg <= cs_eff[SUM_W-1];
              div_quo <= cs_eff[SUM_W-1] ? DIV_W'(-cs_eff) : DIV_W'(cs_eff);
              div_d   <= (num_rows == '0) ? NR_W'(1) : num_rows;
              div_rem <= '0;
              div_cnt <= '0;
              state   <= S_CDIV;
            end else begin
              res_value <= a_sat;
              state     <= S_OUT;
            end
          end
        end
        S_CDIV: begin
          div_quo <= quo_next;
          div_rem <= div_ge ? NR_W'(div_shift - {1'b0, div_d}) : NR_W'(div_shift);
          div_cnt <= div_cnt + 6'd1;
          if (div_last) begin
            res_value <= sat32((SUM_W+2)'(adj) - (SUM_W+2)'(quo_signed));
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (result.ready) begin
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              col   <= col + AW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/rmic_chk.sv */
// Port-level checker for the row mean block, bound to the top level.
module rmic_chk (
  input logic        clk,
  input logic        rst,
  input logic        elem_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_value,
  input logic [5:0]  res_column,
  input logic        res_last,
  input logic        cfg_ready
);

  // A held result beat keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_column)
      && $stable(res_last))
    else $error("result beat changed while stalled");

  // No element is taken while a row is being delivered.
  a_no_load_on_emit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !elem_ready)
    else $error("element accepted during row delivery");

  // Each column passes through the read and adjust states, so beats never come back to back.
  a_beat_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> !res_valid)
    else $error("result beats closer than the column sweep allows");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && elem_ready && cfg_ready)
    else $error("block not idle after reset");

endmodule

bind row_mean_impute_and_center rmic_chk u_rmic_chk (
  .clk        (clk),
  .rst        (rst),
  .elem_ready (elem.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_value  (result.result_value),
  .res_column (result.column),
  .res_last   (result.row_last),
  .cfg_ready  (cfg.ready)
);
